// File: sv/clme_pkg.sv
package clme_pkg;

    // store depths and derived address widths
    localparam int INPUT_DEPTH  = 4096;
    localparam int WEIGHT_DEPTH = 32768;
    localparam int BIAS_DEPTH   = 512;

    localparam int IN_AW = (INPUT_DEPTH  > 1) ? $clog2(INPUT_DEPTH)  : 1;
    localparam int WT_AW = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
    localparam int BS_AW = (BIAS_DEPTH   > 1) ? $clog2(BIAS_DEPTH)   : 1;

    // data widths
    localparam int DATA_W = 16;
    localparam int PROD_W = 2 * DATA_W;
    localparam int ACC_W  = 50;
    localparam int FRAC_W = 8;
    localparam int Q_W    = ACC_W - FRAC_W;

    // widest flat input and weight addresses the field widths can produce
    localparam int IA_W = 25;
    localparam int WA_W = 28;

    localparam logic signed [DATA_W-1:0] OUT_MAX = 16'sh7fff;
    localparam logic signed [DATA_W-1:0] OUT_MIN = 16'sh8000;

    // item kinds
    localparam logic [1:0] KIND_LOAD_INPUT  = 2'd0;
    localparam logic [1:0] KIND_LOAD_WEIGHT = 2'd1;
    localparam logic [1:0] KIND_LOAD_BIAS   = 2'd2;
    localparam logic [1:0] KIND_COMPUTE     = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_IN_WIDTH    = 3'd0;
    localparam logic [2:0] REG_IN_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_IN_DEPTH    = 3'd2;
    localparam logic [2:0] REG_FILT_WIDTH  = 3'd3;
    localparam logic [2:0] REG_FILT_HEIGHT = 3'd4;
    localparam logic [2:0] REG_NUM_FILTERS = 3'd5;

    typedef struct packed {
        logic [6:0] in_width;
        logic [6:0] in_height;
        logic [9:0] in_depth;
        logic [3:0] filt_width;
        logic [3:0] filt_height;
        logic [9:0] num_filters;
    } cfg_t;

    // sequencer to multiply-accumulate unit
    typedef struct packed {
        logic bias_load;
        logic bias_ok;
        logic step;
        logic in_ok;
        logic wt_ok;
    } mac_ctl_t;

endpackage

// File: sv/clme_ram.sv
module clme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic [AW-1:0]        rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

// File: sv/clme_mac.sv
module clme_mac (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  clme_pkg::mac_ctl_t               ctl,
    input  logic [clme_pkg::DATA_W-1:0]      in_rdata,
    input  logic [clme_pkg::DATA_W-1:0]      wt_rdata,
    input  logic [clme_pkg::DATA_W-1:0]      bias_rdata,
    output logic                             busy,
    output logic signed [clme_pkg::DATA_W-1:0] sum_value,
    output logic                             sum_sat
);

    logic                                  step_d_reg;
    logic                                  in_ok_d_reg;
    logic                                  wt_ok_d_reg;
    logic                                  prod_vld_reg;
    logic signed [clme_pkg::PROD_W-1:0]    prod_reg;
    logic signed [clme_pkg::ACC_W-1:0]     acc_reg;

    logic signed [clme_pkg::DATA_W-1:0]    mul_a;
    logic signed [clme_pkg::DATA_W-1:0]    mul_b;
    logic signed [clme_pkg::DATA_W-1:0]    bias_s;
    logic signed [clme_pkg::PROD_W-1:0]    prod_next;
    logic signed [clme_pkg::ACC_W-1:0]     acc_next;
    logic signed [clme_pkg::Q_W-1:0]       q;
    logic signed [clme_pkg::Q_W-1:0]       q_max;
    logic signed [clme_pkg::Q_W-1:0]       q_min;

    // align the read flags with the registered store data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_d_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end else begin
            step_d_reg   <= ctl.step;
            prod_vld_reg <= step_d_reg;
        end
        in_ok_d_reg <= ctl.in_ok;
        wt_ok_d_reg <= ctl.wt_ok;
    end

    // out-of-store addresses read as zero
    assign mul_a     = in_ok_d_reg ? $signed(in_rdata) : '0;
    assign mul_b     = wt_ok_d_reg ? $signed(wt_rdata) : '0;
    assign prod_next = mul_a * mul_b;
    assign bias_s    = ctl.bias_ok ? $signed(bias_rdata) : '0;

    // product register
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    // accumulator: preset with the bias in Q16.16, then add products
    always_comb begin
        acc_next = acc_reg;
        if (ctl.bias_load) begin
            acc_next = clme_pkg::ACC_W'(bias_s) <<< clme_pkg::FRAC_W;
        end else if (prod_vld_reg) begin
            acc_next = acc_reg + clme_pkg::ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign busy = step_d_reg | prod_vld_reg;

    // drop the low fraction bits (floor) and saturate to Q8.8
    assign q     = acc_reg[clme_pkg::ACC_W-1:clme_pkg::FRAC_W];
    assign q_max = clme_pkg::Q_W'(clme_pkg::OUT_MAX);
    assign q_min = clme_pkg::Q_W'(clme_pkg::OUT_MIN);

    always_comb begin
        sum_sat   = 1'b0;
        sum_value = q[clme_pkg::DATA_W-1:0];
        if (q > q_max) begin
            sum_sat   = 1'b1;
            sum_value = clme_pkg::OUT_MAX;
        end else if (q < q_min) begin
            sum_sat   = 1'b1;
            sum_value = clme_pkg::OUT_MIN;
        end
    end

endmodule

// File: sv/clme_seq.sv
module clme_seq (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  clme_pkg::cfg_t                cfg,
    input  logic                          start,
    input  logic [8:0]                    start_filter,
    input  logic [5:0]                    start_row,
    input  logic [5:0]                    start_col,
    input  logic                          mac_busy,
    input  logic                          out_free,
    output logic                          idle,
    output logic [clme_pkg::IN_AW-1:0]    in_raddr,
    output logic [clme_pkg::WT_AW-1:0]    wt_raddr,
    output logic [clme_pkg::BS_AW-1:0]    bias_raddr,
    output clme_pkg::mac_ctl_t            mac_ctl,
    output logic                          done,
    output logic                          done_err
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SETUP1 = 3'd1;
    localparam logic [2:0] S_SETUP2 = 3'd2;
    localparam logic [2:0] S_SETUP3 = 3'd3;
    localparam logic [2:0] S_RUN    = 3'd4;
    localparam logic [2:0] S_DRAIN  = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;
    logic                        err_reg;
    logic [8:0]                  f_reg;
    logic [5:0]                  row_reg;
    logic [5:0]                  col_reg;
    logic [13:0]                 plane_reg;
    logic [7:0]                  fplane_reg;
    logic [12:0]                 rowoff_reg;
    logic [16:0]                 ffp_reg;
    logic [3:0]                  x_reg;
    logic [3:0]                  y_reg;
    logic [9:0]                  d_reg;
    logic [clme_pkg::IA_W-1:0]   ia_reg;
    logic [clme_pkg::IA_W-1:0]   iarow_reg;
    logic [clme_pkg::IA_W-1:0]   iachan_reg;
    logic [clme_pkg::WA_W-1:0]   wa_reg;

    logic                        range_bad;
    logic [6:0]                  row_lim;
    logic [6:0]                  col_lim;
    logic                        x_last;
    logic                        y_last;
    logic                        d_last;
    logic                        depth_zero;
    logic [clme_pkg::IA_W-1:0]   iarow_step;
    logic [clme_pkg::IA_W-1:0]   iachan_step;

    // position check against the output map
    assign row_lim = cfg.in_height - {3'b0, cfg.filt_height};
    assign col_lim = cfg.in_width  - {3'b0, cfg.filt_width};

    always_comb begin
        range_bad = (cfg.in_width == '0) || (cfg.in_height == '0)
                 || (cfg.filt_width == '0) || (cfg.filt_height == '0)
                 || (cfg.num_filters == '0)
                 || ({3'b0, cfg.filt_width} > cfg.in_width)
                 || ({3'b0, cfg.filt_height} > cfg.in_height)
                 || ({1'b0, f_reg} >= cfg.num_filters)
                 || ({1'b0, row_reg} > row_lim)
                 || ({1'b0, col_reg} > col_lim);
    end

    // loop bounds of the walk
    assign x_last     = (x_reg == (cfg.filt_width  - 4'd1));
    assign y_last     = (y_reg == (cfg.filt_height - 4'd1));
    assign d_last     = (d_reg == (cfg.in_depth    - 10'd1));
    assign depth_zero = (cfg.in_depth == '0);

    assign iarow_step  = iarow_reg  + clme_pkg::IA_W'(cfg.in_width);
    assign iachan_step = iachan_reg + clme_pkg::IA_W'(plane_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    state_next = S_SETUP1;
                end
            end
            S_SETUP1: begin
                state_next = range_bad ? S_FINISH : S_SETUP2;
            end
            S_SETUP2: begin
                state_next = S_SETUP3;
            end
            S_SETUP3: begin
                state_next = depth_zero ? S_DRAIN : S_RUN;
            end
            S_RUN: begin
                if (x_last && y_last && d_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!mac_busy) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // capture the position and the error verdict
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_reg <= 1'b0;
        end else if (state_reg == S_IDLE && start) begin
            err_reg <= 1'b0;
        end else if (state_reg == S_SETUP1) begin
            err_reg <= range_bad;
        end
        if (state_reg == S_IDLE && start) begin
            f_reg   <= start_filter;
            row_reg <= start_row;
            col_reg <= start_col;
        end
    end

    // setup products, one small multiply per register
    always_ff @(posedge aclk) begin
        if (state_reg == S_SETUP1) begin
            plane_reg  <= {7'b0, cfg.in_width} * {7'b0, cfg.in_height};
            fplane_reg <= {4'b0, cfg.filt_width} * {4'b0, cfg.filt_height};
            rowoff_reg <= {7'b0, row_reg} * {6'b0, cfg.in_width};
        end
        if (state_reg == S_SETUP2) begin
            ffp_reg <= {8'b0, f_reg} * {9'b0, fplane_reg};
        end
    end

    // address walkers: input by channel, row and column, weights linear
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_SETUP2: begin
                iachan_reg <= clme_pkg::IA_W'(rowoff_reg) + clme_pkg::IA_W'(col_reg);
                iarow_reg  <= clme_pkg::IA_W'(rowoff_reg) + clme_pkg::IA_W'(col_reg);
                ia_reg     <= clme_pkg::IA_W'(rowoff_reg) + clme_pkg::IA_W'(col_reg);
            end
            S_SETUP3: begin
                wa_reg <= clme_pkg::WA_W'({10'b0, ffp_reg} * {17'b0, cfg.in_depth});
                x_reg  <= '0;
                y_reg  <= '0;
                d_reg  <= '0;
            end
            S_RUN: begin
                wa_reg <= wa_reg + clme_pkg::WA_W'(1);
                if (!x_last) begin
                    x_reg  <= x_reg + 4'd1;
                    ia_reg <= ia_reg + clme_pkg::IA_W'(1);
                end else if (!y_last) begin
                    x_reg     <= '0;
                    y_reg     <= y_reg + 4'd1;
                    iarow_reg <= iarow_step;
                    ia_reg    <= iarow_step;
                end else begin
                    x_reg      <= '0;
                    y_reg      <= '0;
                    d_reg      <= d_reg + 10'd1;
                    iachan_reg <= iachan_step;
                    iarow_reg  <= iachan_step;
                    ia_reg     <= iachan_step;
                end
            end
            default: begin
            end
        endcase
    end

    // store reads and unit control
    assign in_raddr   = clme_pkg::IN_AW'(ia_reg);
    assign wt_raddr   = clme_pkg::WT_AW'(wa_reg);
    assign bias_raddr = clme_pkg::BS_AW'(f_reg);

    always_comb begin
        mac_ctl.bias_load = (state_reg == S_SETUP3);
        mac_ctl.bias_ok   = (32'(f_reg) < clme_pkg::BIAS_DEPTH);
        mac_ctl.step      = (state_reg == S_RUN);
        mac_ctl.in_ok     = (ia_reg < clme_pkg::IA_W'(clme_pkg::INPUT_DEPTH));
        mac_ctl.wt_ok     = (wa_reg < clme_pkg::WA_W'(clme_pkg::WEIGHT_DEPTH));
    end

    assign idle     = (state_reg == S_IDLE);
    assign done     = (state_reg == S_FINISH) && out_free;
    assign done_err = err_reg;

endmodule

// File: sv/conv_layer_mac_engine_core.sv
// Convolution layer engine: valid, stride-one, multichannel 2D convolution with a
// per-filter bias in signed Q8.8. Load beats (kind 0/1/2) write one input-map value,
// weight or bias into its store; they give no result. A compute beat (kind 3) runs
// through the setup, run and drain states, then its result is registered on the output:
// one shared 16x16 multiply-accumulate unit takes one product per cycle, paced by the
// single read port of the input and weight stores. A position outside the output map,
// a filter index not below num_filters or an invalid configuration returns zero with
// range_error set, skipping the run and drain states. The next beat can be taken in
// the same cycle the result appears; a finished compute beat waits while an earlier
// result still sits in the output register, and no beat is taken meanwhile. Configuration
// must be written by the user only while the block is idle; the block does not enforce it.
module conv_layer_mac_engine_core (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [9:0]         cfg_wdata,
    // input beats
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic [14:0]        s_load_addr,
    input  logic signed [15:0] s_load_value,
    input  logic [8:0]         s_filter_sel,
    input  logic [5:0]         s_out_row,
    input  logic [5:0]         s_out_col,
    // result beats
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_out_value,
    output logic               m_saturated,
    output logic               m_range_error
);

    clme_pkg::cfg_t                     cfg_reg;
    clme_pkg::mac_ctl_t                 mac_ctl;

    logic                               s_fire;
    logic                               in_we;
    logic                               wt_we;
    logic                               bias_we;
    logic                               start;
    logic                               seq_idle;
    logic                               mac_busy;
    logic                               out_free;
    logic                               done;
    logic                               done_err;
    logic [clme_pkg::IN_AW-1:0]         in_raddr;
    logic [clme_pkg::WT_AW-1:0]         wt_raddr;
    logic [clme_pkg::BS_AW-1:0]         bias_raddr;
    logic [clme_pkg::DATA_W-1:0]        in_rdata;
    logic [clme_pkg::DATA_W-1:0]        wt_rdata;
    logic [clme_pkg::DATA_W-1:0]        bias_rdata;
    logic signed [clme_pkg::DATA_W-1:0] sum_value;
    logic                               sum_sat;

    logic                               m_valid_reg;
    logic signed [15:0]                 m_out_value_reg;
    logic                               m_saturated_reg;
    logic                               m_range_error_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.in_width    <= 7'd28;
            cfg_reg.in_height   <= 7'd28;
            cfg_reg.in_depth    <= 10'd1;
            cfg_reg.filt_width  <= 4'd5;
            cfg_reg.filt_height <= 4'd5;
            cfg_reg.num_filters <= 10'd20;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                clme_pkg::REG_IN_WIDTH:    cfg_reg.in_width    <= cfg_wdata[6:0];
                clme_pkg::REG_IN_HEIGHT:   cfg_reg.in_height   <= cfg_wdata[6:0];
                clme_pkg::REG_IN_DEPTH:    cfg_reg.in_depth    <= cfg_wdata;
                clme_pkg::REG_FILT_WIDTH:  cfg_reg.filt_width  <= cfg_wdata[3:0];
                clme_pkg::REG_FILT_HEIGHT: cfg_reg.filt_height <= cfg_wdata[3:0];
                clme_pkg::REG_NUM_FILTERS: cfg_reg.num_filters <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // input beat decode
    assign s_ready = seq_idle && aresetn;
    assign s_fire  = s_valid && s_ready;
    assign in_we   = s_fire && (s_kind == clme_pkg::KIND_LOAD_INPUT)
                  && (32'(s_load_addr) < clme_pkg::INPUT_DEPTH);
    assign wt_we   = s_fire && (s_kind == clme_pkg::KIND_LOAD_WEIGHT)
                  && (32'(s_load_addr) < clme_pkg::WEIGHT_DEPTH);
    assign bias_we = s_fire && (s_kind == clme_pkg::KIND_LOAD_BIAS)
                  && (32'(s_load_addr) < clme_pkg::BIAS_DEPTH);
    assign start   = s_fire && (s_kind == clme_pkg::KIND_COMPUTE);

    // stores
    clme_ram #(
        .WIDTH (clme_pkg::DATA_W),
        .DEPTH (clme_pkg::INPUT_DEPTH)
    ) u_input_ram (
        .aclk    (aclk),
        .wr_en   (in_we),
        .wr_addr (clme_pkg::IN_AW'(s_load_addr)),
        .wr_data (s_load_value),
        .rd_addr (in_raddr),
        .rd_data (in_rdata)
    );

    clme_ram #(
        .WIDTH (clme_pkg::DATA_W),
        .DEPTH (clme_pkg::WEIGHT_DEPTH)
    ) u_weight_ram (
        .aclk    (aclk),
        .wr_en   (wt_we),
        .wr_addr (clme_pkg::WT_AW'(s_load_addr)),
        .wr_data (s_load_value),
        .rd_addr (wt_raddr),
        .rd_data (wt_rdata)
    );

    clme_ram #(
        .WIDTH (clme_pkg::DATA_W),
        .DEPTH (clme_pkg::BIAS_DEPTH)
    ) u_bias_ram (
        .aclk    (aclk),
        .wr_en   (bias_we),
        .wr_addr (clme_pkg::BS_AW'(s_load_addr)),
        .wr_data (s_load_value),
        .rd_addr (bias_raddr),
        .rd_data (bias_rdata)
    );

    // sequencer and address walk
    clme_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .start        (start),
        .start_filter (s_filter_sel),
        .start_row    (s_out_row),
        .start_col    (s_out_col),
        .mac_busy     (mac_busy),
        .out_free     (out_free),
        .idle         (seq_idle),
        .in_raddr     (in_raddr),
        .wt_raddr     (wt_raddr),
        .bias_raddr   (bias_raddr),
        .mac_ctl      (mac_ctl),
        .done         (done),
        .done_err     (done_err)
    );

    // shared multiply-accumulate unit
    clme_mac u_mac (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (mac_ctl),
        .in_rdata   (in_rdata),
        .wt_rdata   (wt_rdata),
        .bias_rdata (bias_rdata),
        .busy       (mac_busy),
        .sum_value  (sum_value),
        .sum_sat    (sum_sat)
    );

    // output register
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (done) begin
            m_out_value_reg   <= done_err ? '0 : sum_value;
            m_saturated_reg   <= done_err ? 1'b0 : sum_sat;
            m_range_error_reg <= done_err;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_value   = m_out_value_reg;
    assign m_saturated   = m_saturated_reg;
    assign m_range_error = m_range_error_reg;

    // a range error carries a zero, unsaturated value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_range_error |-> (m_out_value == '0) && !m_saturated)
        else $error("range error beat with nonzero payload");

    // a saturated result sits at one of the rails
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated
            |-> (m_out_value == clme_pkg::OUT_MAX) || (m_out_value == clme_pkg::OUT_MIN))
        else $error("saturated flag without clipped value");

    // a compute beat holds off the input side on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_kind == clme_pkg::KIND_COMPUTE) |=> !s_ready)
        else $error("input accepted while computing");

    // the unit is quiet whenever the block is idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !mac_busy)
        else $error("multiply-accumulate busy while idle");

endmodule
